@@ design/double_ended_queue_core_assert.svh @@
// Assertion macros shared by the deque modules.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define DEQ_ASSERT_CLK(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("deque assertion failed");

`define DEQ_ASSERT(label, prop) \
  `DEQ_ASSERT_CLK(label, clk, rst, prop)

`else

`define DEQ_ASSERT_CLK(label, clock, reset, prop)

`define DEQ_ASSERT(label, prop)

`endif

`endif

@@ design/deq_pkg.sv @@
package deq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned DATA_WIDTH_DEFAULT = 32;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned FIELD_W = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SIZE       = 3'd4,
    REQ_EMPTY      = 3'd5,
    REQ_PEEK_FRONT = 3'd6,
    REQ_PEEK_BACK  = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    IMM_SIZE,
    IMM_EMPTY,
    IMM_MISSING
  } imm_sel_t;

  typedef enum logic [1:0] {
    SRC_IMM_NOW,
    SRC_IMM_REG,
    SRC_MEM
  } out_src_t;

  typedef struct packed {
    logic      put_front;
    logic      put_back;
    logic      rd_front;
    logic      rd_back;
    logic      pop;
    imm_sel_t  imm_sel;
    logic      save_imm;
    logic      load_out;
    out_src_t  out_src;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic out_free;
  } status_t;

endpackage

@@ design/deq_ctrl.sv @@
`include "double_ended_queue_core_assert.svh"

module deq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [deq_pkg::REQ_W-1:0]  req_type,
  input  deq_pkg::status_t           sts,
  output deq_pkg::cmd_t              cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_PEND
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   immediate;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.imm_sel = deq_pkg::IMM_SIZE;
    cmd.out_src = deq_pkg::SRC_IMM_NOW;
    immediate   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (deq_pkg::req_t'(req_type))
            deq_pkg::REQ_PUSH_FRONT: cmd.put_front = 1'b1;
            deq_pkg::REQ_PUSH_BACK:  cmd.put_back = 1'b1;
            deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_PEEK_FRONT,
            deq_pkg::REQ_POP_BACK, deq_pkg::REQ_PEEK_BACK: begin
              if (sts.empty) begin
                immediate   = 1'b1;
                cmd.imm_sel = deq_pkg::IMM_MISSING;
              end else begin
                cmd.rd_front = (deq_pkg::req_t'(req_type) == deq_pkg::REQ_POP_FRONT) ||
                               (deq_pkg::req_t'(req_type) == deq_pkg::REQ_PEEK_FRONT);
                cmd.rd_back  = !cmd.rd_front;
                cmd.pop      = (deq_pkg::req_t'(req_type) == deq_pkg::REQ_POP_FRONT) ||
                               (deq_pkg::req_t'(req_type) == deq_pkg::REQ_POP_BACK);
                state_next   = S_READ;
              end
            end
            deq_pkg::REQ_SIZE: begin
              immediate   = 1'b1;
              cmd.imm_sel = deq_pkg::IMM_SIZE;
            end
            deq_pkg::REQ_EMPTY: begin
              immediate   = 1'b1;
              cmd.imm_sel = deq_pkg::IMM_EMPTY;
            end
            default: ;
          endcase
          if (immediate) begin
            if (sts.out_free) begin
              cmd.load_out = 1'b1;
              cmd.out_src  = deq_pkg::SRC_IMM_NOW;
            end else begin
              cmd.save_imm = 1'b1;
              state_next   = S_PEND;
            end
          end
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_src  = deq_pkg::SRC_MEM;
          state_next   = S_IDLE;
        end
      end
      S_PEND: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_src  = deq_pkg::SRC_IMM_REG;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DEQ_ASSERT(a_load_needs_room, cmd.load_out |-> sts.out_free)
  `DEQ_ASSERT(a_read_follows_issue,
    (state == S_READ && $past(state) != S_READ) |->
      $past(cmd.rd_front || cmd.rd_back))
  `DEQ_ASSERT(a_no_issue_while_busy,
    (state != S_IDLE) |-> !(cmd.put_front || cmd.put_back || cmd.rd_front || cmd.rd_back))

endmodule

@@ design/deq_dpath.sv @@
`include "double_ended_queue_core_assert.svh"

module deq_dpath #(
  parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  deq_pkg::cmd_t                cmd,
  output deq_pkg::status_t             sts,
  input  logic [deq_pkg::FIELD_W-1:0]  push_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [deq_pkg::FIELD_W-1:0]  reply_data,
  output logic                         reply_missing
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [PTR_W-1:0]            head;
  logic [PTR_W-1:0]            tail;
  logic [CNT_W-1:0]            count;
  logic [PTR_W-1:0]            head_inc;
  logic [PTR_W-1:0]            head_dec;
  logic [PTR_W-1:0]            tail_inc;
  logic [PTR_W-1:0]            tail_dec;
  logic [DATA_WIDTH-1:0]       rd_data;
  logic [deq_pkg::FIELD_W-1:0] imm_data;
  logic                        imm_missing;
  logic [deq_pkg::FIELD_W-1:0] imm_data_now;
  logic                        imm_missing_now;
  logic                        full;
  logic                        do_put_front;
  logic                        do_put_back;
  logic                        do_read;
  logic [PTR_W-1:0]            wr_addr;
  logic [PTR_W-1:0]            rd_addr;

  assign head_inc = (head == PTR_LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? PTR_LAST : head - 1'b1;
  assign tail_inc = (tail == PTR_LAST) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? PTR_LAST : tail - 1'b1;

  assign full         = (count == CNT_FULL);
  assign do_put_front = cmd.put_front && !full;
  assign do_put_back  = cmd.put_back && !full;
  assign do_read      = cmd.rd_front || cmd.rd_back;
  assign wr_addr      = cmd.put_front ? head_dec : tail;
  assign rd_addr      = cmd.rd_front ? head : tail_dec;

  assign sts.empty    = (count == '0);
  assign sts.out_free = !out_valid || !out_stall;

  always_comb begin
    imm_data_now    = '0;
    imm_missing_now = 1'b0;
    unique case (cmd.imm_sel)
      deq_pkg::IMM_SIZE:    imm_data_now = deq_pkg::FIELD_W'(count);
      deq_pkg::IMM_EMPTY:   imm_data_now = deq_pkg::FIELD_W'(sts.empty);
      deq_pkg::IMM_MISSING: imm_missing_now = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_put_front || do_put_back) begin
      mem[wr_addr] <= DATA_WIDTH'(push_value);
    end
    if (do_read) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_put_front) begin
        head  <= head_dec;
        count <= count + 1'b1;
      end else if (do_put_back) begin
        tail  <= tail_inc;
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        if (cmd.rd_front) begin
          head <= head_inc;
        end else begin
          tail <= tail_dec;
        end
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_imm) begin
      imm_data    <= imm_data_now;
      imm_missing <= imm_missing_now;
    end
    if (cmd.load_out) begin
      unique case (cmd.out_src)
        deq_pkg::SRC_IMM_NOW: begin
          reply_data    <= imm_data_now;
          reply_missing <= imm_missing_now;
        end
        deq_pkg::SRC_IMM_REG: begin
          reply_data    <= imm_data;
          reply_missing <= imm_missing;
        end
        deq_pkg::SRC_MEM: begin
          reply_data    <= deq_pkg::FIELD_W'(rd_data);
          reply_missing <= 1'b0;
        end
        default: begin
          reply_data    <= '0;
          reply_missing <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `DEQ_ASSERT(a_count_bound, count <= CNT_FULL)
  `DEQ_ASSERT(a_full_push_dropped,
    ((cmd.put_front || cmd.put_back) && full) |=> $stable(count))
  `DEQ_ASSERT(a_pop_decrements,
    (cmd.pop && !sts.empty) |=> (count == $past(count) - 1'b1))

endmodule

@@ design/double_ended_queue_core.sv @@
// Double-ended queue of DATA_WIDTH-bit words held in a DEPTH-entry ring buffer
// with head and tail pointers and a word count; stored words may take any value.
// Requests enter on the in channel and each pop, peek, size or empty request
// returns one word on the out channel, where a pop or peek on an empty queue
// sets reply_missing. A push to a full queue is dropped without a reply. Pushes,
// size, empty and pops or peeks of an empty queue are handled in the idle
// state; a pop or peek that finds data goes through a read state, as the word
// store is a single memory with a registered read port. A finished reply waits
// in the output register while the next request is taken; a reply that cannot
// enter it waits in the datapath. The store needs no clearing after reset.
module double_ended_queue_core #(
  parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [deq_pkg::REQ_W-1:0]    req_type,
  input  logic [deq_pkg::FIELD_W-1:0]  push_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [deq_pkg::FIELD_W-1:0]  reply_data,
  output logic                         reply_missing
);

  deq_pkg::cmd_t    cmd;
  deq_pkg::status_t sts;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  deq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .push_value    (push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .reply_data    (reply_data),
    .reply_missing (reply_missing)
  );

endmodule

@@ tb/double_ended_queue_core_tb.sv @@
`timescale 1ns / 1ps

module double_ended_queue_core_tb;

  localparam int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  typedef struct {
    deq_pkg::req_t kind;
    logic [31:0]   word;
    bit            hold;
  } request_t;

  typedef struct packed {
    logic [31:0] data;
    logic        missing;
  } reply_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  req_type = '0;
  logic [31:0] push_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] reply_data;
  logic        reply_missing;

  double_ended_queue_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .push_value(push_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .reply_data(reply_data),
    .reply_missing(reply_missing)
  );

  request_t request_backlog[$];
  reply_t   pending_replies[$];

  logic [31:0]      deque_words [DEPTH];
  logic [PTR_W-1:0] front_idx = '0;
  logic [PTR_W-1:0] back_idx = '0;
  logic [PTR_W:0]   word_count = '0;

  int words_in = 0;
  int replies_seen = 0;
  int missing_seen = 0;
  int dropped_pushes = 0;
  int peak_fill = 0;
  int mismatches = 0;
  int total_items = 0;
  int gen_fill = 0;
  request_t issue;
  reply_t   want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_odds();
    return (words_in >= 700 && words_in < 1000) ? 0 : 16;
  endfunction

  task automatic predict_reply(input deq_pkg::req_t kind, input logic [31:0] word);
    reply_t           r;
    logic [PTR_W-1:0] last_idx;
    r = '0;
    last_idx = back_idx - 1'b1;
    case (kind)
      deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
        if (word_count < DEPTH) begin
          if (kind == deq_pkg::REQ_PUSH_FRONT) begin
            front_idx = front_idx - 1'b1;
            deque_words[front_idx] = word;
          end else begin
            deque_words[back_idx] = word;
            back_idx = back_idx + 1'b1;
          end
          word_count = word_count + 1'b1;
          if (word_count > peak_fill) peak_fill = int'(word_count);
        end else begin
          dropped_pushes++;
        end
      end
      deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_PEEK_FRONT: begin
        if (word_count == 0) begin
          r.missing = 1'b1;
        end else begin
          r.data = deque_words[front_idx];
          if (kind == deq_pkg::REQ_POP_FRONT) begin
            front_idx = front_idx + 1'b1;
            word_count = word_count - 1'b1;
          end
        end
      end
      deq_pkg::REQ_POP_BACK, deq_pkg::REQ_PEEK_BACK: begin
        if (word_count == 0) begin
          r.missing = 1'b1;
        end else begin
          r.data = deque_words[last_idx];
          if (kind == deq_pkg::REQ_POP_BACK) begin
            back_idx = last_idx;
            word_count = word_count - 1'b1;
          end
        end
      end
      deq_pkg::REQ_SIZE: r.data = 32'(word_count);
      default: r.data = (word_count == 0) ? 32'd1 : 32'd0;
    endcase
    if (kind != deq_pkg::REQ_PUSH_FRONT && kind != deq_pkg::REQ_PUSH_BACK) begin
      pending_replies.insert(pending_replies.size(), r);
      if (r.missing) missing_seen++;
    end
  endtask

  task automatic queue_request(input deq_pkg::req_t kind, input logic [31:0] word,
                               input bit hold);
    request_t q;
    q.kind = kind;
    q.word = word;
    q.hold = hold;
    request_backlog.insert(request_backlog.size(), q);
    if ((kind == deq_pkg::REQ_PUSH_FRONT || kind == deq_pkg::REQ_PUSH_BACK)
        && gen_fill < DEPTH) begin
      gen_fill++;
    end else if ((kind == deq_pkg::REQ_POP_FRONT || kind == deq_pkg::REQ_POP_BACK)
                 && gen_fill > 0) begin
      gen_fill--;
    end
  endtask

  function automatic deq_pkg::req_t pick_kind(input int push_pct, input int pop_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      return $urandom_range(1) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT;
    end
    if (roll < push_pct + pop_pct) begin
      return $urandom_range(1) ? deq_pkg::REQ_POP_BACK : deq_pkg::REQ_POP_FRONT;
    end
    return deq_pkg::req_t'($urandom_range(4, 7));
  endfunction

  function automatic logic [31:0] any_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_reply(deq_pkg::req_t'(req_type), push_value);
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (request_backlog.size() != 0
            && !(request_backlog[0].hold && pending_replies.size() != 0)
            && $urandom_range(99) >= idle_odds()) begin
          issue = request_backlog[0];
          request_backlog.delete(0);
          in_valid <= 1'b1;
          req_type <= issue.kind;
          push_value <= issue.word;
        end else begin
          in_valid <= 1'b0;
          req_type <= 3'($urandom_range(7));
          push_value <= $urandom();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (pending_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected word data=%h missing=%b", $realtime, reply_data,
                     reply_missing);
          end
        end else begin
          want = pending_replies[0];
          pending_replies.delete(0);
          if (reply_data !== want.data || reply_missing !== want.missing) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: word mismatch: expected data=%h missing=%b, %s data=%h missing=%b",
                       $realtime, want.data, want.missing, "got", reply_data,
                       reply_missing);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_odds());
    end
  end

  initial begin
    queue_request(deq_pkg::REQ_POP_FRONT, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_POP_BACK, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_PEEK_FRONT, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_PEEK_BACK, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_SIZE, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_EMPTY, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_PUSH_BACK, 32'h0000_0000, 1'b0);
    queue_request(deq_pkg::REQ_PUSH_FRONT, 32'hffff_ffff, 1'b0);
    queue_request(deq_pkg::REQ_PEEK_FRONT, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_PEEK_BACK, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_SIZE, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_EMPTY, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_PUSH_BACK, 32'h8000_0001, 1'b0);
    queue_request(deq_pkg::REQ_POP_BACK, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_POP_FRONT, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_POP_FRONT, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_POP_BACK, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_PUSH_FRONT, 32'h5a5a_a5a5, 1'b0);
    queue_request(deq_pkg::REQ_POP_BACK, $urandom(), 1'b0);
    queue_request(deq_pkg::REQ_EMPTY, $urandom(), 1'b0);

    repeat (100) queue_request(deq_pkg::req_t'($urandom_range(7)), any_word(), 1'b0);
    while (gen_fill < DEPTH) queue_request(pick_kind(95, 2), any_word(), 1'b0);
    queue_request(pick_kind(60, 0), any_word(), 1'b1);
    repeat (39) queue_request(pick_kind(60, 0), any_word(), 1'b0);
    while (gen_fill > 600) queue_request(pick_kind(5, 88), any_word(), 1'b0);
    total_items = request_backlog.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (words_in != total_items || pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d requests and checked %0d replies, %0d of them on an empty queue.",
             words_in, replies_seen, missing_seen);
    $display("The queue filled to %0d of %0d words and dropped %0d pushes while full.",
             peak_fill, DEPTH, dropped_pushes);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
